// File: hdl/radix_integer_stream_parser_top_defines.svh
// Assertion macros for the radix integer stream parser.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef RADIX_INTEGER_STREAM_PARSER_TOP_DEFINES_SVH
`define RADIX_INTEGER_STREAM_PARSER_TOP_DEFINES_SVH

// Property holds on every clock edge out of reset.
`define RSP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Overlapped implication, checked out of reset.
`define RSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define RSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/rsp_pkg.sv
// Shared types, constants and digit decode for the radix integer stream parser.
// No dependencies.
`timescale 1ns / 1ps

package rsp_pkg;

  localparam int VALUE_W  = 31;
  localparam int STATUS_W = 2;
  localparam int DIGIT_W  = 6;
  localparam int RADIX_W  = 6;
  localparam int CH_W     = 8;
  // acc (31 bits) * base (<= 36) + digit fits in 37 bits
  localparam int SUM_W    = VALUE_W + DIGIT_W;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [DIGIT_W-1:0] NO_DIGIT    = 6'd36;

  localparam logic [CH_W-1:0] CH_LF = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR = 8'h0D;
  localparam logic [CH_W-1:0] CH_0  = 8'h30;
  localparam logic [CH_W-1:0] CH_9  = 8'h39;
  localparam logic [CH_W-1:0] CH_LA = 8'h61;
  localparam logic [CH_W-1:0] CH_LZ = 8'h7A;

  localparam logic [STATUS_W-1:0] ST_INT   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOINT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_END   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CALC   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_DRAIN  = 4'b1000
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
  } res_t;

  // Digit value of a byte, NO_DIGIT when it is no digit in any base.
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] t;
    begin
      t = '0;
      if (c >= CH_0 && c <= CH_9) begin
        t = c - CH_0;
        digit_of = t[DIGIT_W-1:0];
      end else if (c >= CH_LA && c <= CH_LZ) begin
        t = c - CH_LA + 8'd10;
        digit_of = t[DIGIT_W-1:0];
      end else begin
        digit_of = NO_DIGIT;
      end
    end
  endfunction

endpackage

// File: hdl/rsp_mac.sv
// Shared multiply-add unit: acc * base + digit, result registered.
// Depends on rsp_pkg.
`timescale 1ns / 1ps

module rsp_mac (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rsp_pkg::VALUE_W-1:0]  acc,
  input  logic [rsp_pkg::RADIX_W-1:0]  base,
  input  logic [rsp_pkg::DIGIT_W-1:0]  dig,
  output logic [rsp_pkg::SUM_W-1:0]    sum_r
);

  logic [rsp_pkg::SUM_W-1:0] prod;
  logic [rsp_pkg::SUM_W-1:0] sum_nxt;

  assign prod    = rsp_pkg::SUM_W'(acc) * rsp_pkg::SUM_W'(base);
  assign sum_nxt = prod + rsp_pkg::SUM_W'(dig);

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

// File: hdl/radix_integer_stream_parser_top.sv
// Radix integer stream parser, top level: sequencer, parse state, output stage.
// Depends on rsp_pkg, rsp_mac and radix_integer_stream_parser_top_defines.svh.
`timescale 1ns / 1ps
//
//  Channel  Dir  Fields (tdata low bit up)            Side bits
//  in_*     in   ch[7:0]                              tuser=action, tlast=line_end
//  out_*    out  status[1:0], value[32:2], zero pad   tlast=last
//  cfg_*    in   radix[5:0] on cfg_wr_data            cfg_wr_en strobe
//
//  A byte is taken in IDLE, passes through the shared multiply-add (CALC)
//  and then DECIDE, and goes back to IDLE when it gives no result.
//  Each result then occupies the output register until it is transferred; the
//  sequencer takes no new byte until the last result of the byte is transferred.
//  Reset: radix 10, seeking a digit, not discarding, output empty. No memory.
//  Stalls: out_tready low holds the output register and the pending result.

`include "radix_integer_stream_parser_top_defines.svh"

module radix_integer_stream_parser_top #(
  parameter int CELL_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // ch[7:0]
  input  logic        in_tuser,     // action: 0 byte, 1 end of input
  input  logic        in_tlast,     // line_end
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // status[1:0], value[32:2], 0 above
  output logic        out_tlast,    // last result of the input transfer
  // configuration
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data   // radix
);

  // cell maximum 2^(bits-1)-1, capped so it fits the value field
  localparam int CELL_EFF = (CELL_BITS > 32) ? 32 : CELL_BITS;
  localparam logic [rsp_pkg::VALUE_W-1:0] CELL_MAX =
    rsp_pkg::VALUE_W'((64'd1 << (CELL_EFF - 1)) - 64'd1);

  rsp_pkg::state_t state_r, state_nxt;

  logic [rsp_pkg::RADIX_W-1:0] radix_r;
  logic                        in_num_r, in_num_nxt;
  logic                        disc_r, disc_nxt;
  logic [rsp_pkg::VALUE_W-1:0] acc_r, acc_nxt;

  // latched item
  logic                        act_r;
  logic [rsp_pkg::CH_W-1:0]    ch_r;
  logic                        eol_r;
  logic [rsp_pkg::DIGIT_W-1:0] dig_r;
  logic [rsp_pkg::RADIX_W-1:0] base_r;
  logic [rsp_pkg::RADIX_W-1:0] base_eff;

  logic [rsp_pkg::SUM_W-1:0]   sum_r;

  // output register plus one pending result
  logic                        out_tvalid_r;
  logic                        out_tlast_r;
  rsp_pkg::res_t               out_res_r;
  logic                        pend_r;
  rsp_pkg::res_t               pend_res_r;

  // decide stage
  logic [1:0]                  n_res;
  rsp_pkg::res_t               r0, r1;
  logic                        is_dig, is_crlf, ovf;
  logic [rsp_pkg::VALUE_W-1:0] acc_tmp, dig_ext;

  logic in_xfer, out_xfer;

  assign in_tready  = (state_r == rsp_pkg::S_IDLE);
  assign in_xfer    = in_tvalid & in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_tlast_r;
  assign out_tdata  = {7'd0, out_res_r.value, out_res_r.status};
  assign out_xfer   = out_tvalid_r & out_tready;

  // out-of-range radix clamps to 2..36
  always_comb begin
    priority if (radix_r < rsp_pkg::RADIX_MIN) begin
      base_eff = rsp_pkg::RADIX_MIN;
    end else if (radix_r > rsp_pkg::RADIX_MAX) begin
      base_eff = rsp_pkg::RADIX_MAX;
    end else begin
      base_eff = radix_r;
    end
  end

  rsp_mac u_mac (
    .clk   (clk),
    .en    (state_r == rsp_pkg::S_CALC),
    .acc   (acc_r),
    .base  (base_r),
    .dig   (dig_r),
    .sum_r (sum_r)
  );

  assign is_dig  = (dig_r < base_r);
  assign is_crlf = (ch_r == rsp_pkg::CH_LF) || (ch_r == rsp_pkg::CH_CR);
  assign ovf     = (sum_r > rsp_pkg::SUM_W'(CELL_MAX));
  assign dig_ext = rsp_pkg::VALUE_W'(dig_r);
  assign acc_tmp = ovf ? dig_ext : sum_r[rsp_pkg::VALUE_W-1:0];

  // results of one byte, in delivery order r0 then r1
  always_comb begin
    n_res      = 2'd0;
    r0         = '{status: rsp_pkg::ST_INT, value: '0};
    r1         = '{status: rsp_pkg::ST_INT, value: '0};
    in_num_nxt = in_num_r;
    acc_nxt    = acc_r;
    disc_nxt   = disc_r;
    if (act_r) begin
      // end of input: flush a pending number, then end status
      if (in_num_r) begin
        r0    = '{status: rsp_pkg::ST_INT, value: acc_r};
        r1    = '{status: rsp_pkg::ST_END, value: '0};
        n_res = 2'd2;
      end else begin
        r0    = '{status: rsp_pkg::ST_END, value: '0};
        n_res = 2'd1;
      end
      in_num_nxt = 1'b0;
      acc_nxt    = '0;
      disc_nxt   = 1'b0;
    end else if (disc_r) begin
      if (eol_r) begin
        disc_nxt = 1'b0;
      end
    end else if (in_num_r) begin
      if (is_dig) begin
        // overflowing digit reports the old number and starts a new one
        if (ovf) begin
          r0    = '{status: rsp_pkg::ST_INT, value: acc_r};
          n_res = 2'd1;
        end
        if (eol_r) begin
          if (ovf) begin
            r1 = '{status: rsp_pkg::ST_INT, value: acc_tmp};
          end else begin
            r0 = '{status: rsp_pkg::ST_INT, value: acc_tmp};
          end
          n_res      = n_res + 2'd1;
          in_num_nxt = 1'b0;
          acc_nxt    = '0;
        end else begin
          acc_nxt = acc_tmp;
        end
      end else begin
        r0         = '{status: rsp_pkg::ST_INT, value: acc_r};
        n_res      = 2'd1;
        in_num_nxt = 1'b0;
        acc_nxt    = '0;
        if (eol_r) begin
          if (!is_crlf) begin
            r1    = '{status: rsp_pkg::ST_NOINT, value: '0};
            n_res = 2'd2;
          end
        end else if (is_crlf) begin
          disc_nxt = 1'b1;   // rest of the line is dropped
        end
      end
    end else begin
      if (is_dig) begin
        if (eol_r) begin
          r0    = '{status: rsp_pkg::ST_INT, value: dig_ext};
          n_res = 2'd1;
        end else begin
          in_num_nxt = 1'b1;
          acc_nxt    = dig_ext;
        end
      end else if (eol_r) begin
        r0    = '{status: rsp_pkg::ST_NOINT, value: '0};
        n_res = 2'd1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsp_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = rsp_pkg::S_CALC;
        end
      end
      rsp_pkg::S_CALC: begin
        state_nxt = rsp_pkg::S_DECIDE;
      end
      rsp_pkg::S_DECIDE: begin
        state_nxt = (n_res != 2'd0) ? rsp_pkg::S_DRAIN : rsp_pkg::S_IDLE;
      end
      rsp_pkg::S_DRAIN: begin
        if (out_xfer && !pend_r) begin
          state_nxt = rsp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rsp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rsp_pkg::S_IDLE;
      radix_r      <= rsp_pkg::RADIX_RESET;
      in_num_r     <= 1'b0;
      disc_r       <= 1'b0;
      acc_r        <= '0;
      out_tvalid_r <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        radix_r <= cfg_wr_data;
      end
      if (state_r == rsp_pkg::S_DECIDE) begin
        in_num_r <= in_num_nxt;
        disc_r   <= disc_nxt;
        acc_r    <= acc_nxt;
        if (n_res != 2'd0) begin
          out_tvalid_r <= 1'b1;
          pend_r       <= (n_res == 2'd2);
        end
      end else if (out_xfer) begin
        if (pend_r) begin
          pend_r <= 1'b0;
        end else begin
          out_tvalid_r <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r  <= in_tuser;
      ch_r   <= in_tdata;
      eol_r  <= in_tlast;
      dig_r  <= rsp_pkg::digit_of(in_tdata);
      base_r <= base_eff;
    end
    if (state_r == rsp_pkg::S_DECIDE) begin
      out_res_r   <= r0;
      out_tlast_r <= (n_res == 2'd1);
      pend_res_r  <= r1;
    end else if (out_xfer && pend_r) begin
      out_res_r   <= pend_res_r;
      out_tlast_r <= 1'b1;
    end
  end

  `RSP_ASSERT_IMP(a_ready_out_empty, in_tready, !out_tvalid_r, "input ready while result held")
  `RSP_ASSERT_IMP(a_pend_has_head, pend_r, out_tvalid_r && !out_tlast_r, "pending result without head")
  `RSP_ASSERT(a_acc_in_range, acc_r <= CELL_MAX, "accumulator above cell maximum")
  `RSP_ASSERT_NXT(a_accept_to_calc, in_xfer, state_r == rsp_pkg::S_CALC, "accepted byte skipped calc")
  `RSP_ASSERT_IMP(a_drain_valid, state_r == rsp_pkg::S_DRAIN, out_tvalid_r, "drain with empty output")

endmodule
